/* hdl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Holds the parser phases, result kinds, error codes and the command word
// that the front end hands to the back end.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX,
    PH_PAIR_BS,
    PH_PAIR_U,
    PH_HEX2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } out_kind_t;

  typedef enum logic [1:0] {
    ERR_MISSING_QUOTE = 2'd0,
    ERR_END_OF_INPUT  = 2'd1,
    ERR_BAD_ESCAPE    = 2'd2,
    ERR_BAD_UNICODE   = 2'd3
  } err_code_t;

  // Trailing operation of a command, after an optional released surrogate.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BYTE,
    OP_CODE,
    OP_CLOSE,
    OP_ERROR
  } op_t;

  typedef struct packed {
    logic        held_en;  // emit the held high surrogate as three bytes first
    logic [15:0] held;     // the held high surrogate
    op_t         op;
    logic [20:0] val;      // raw byte (OP_BYTE) or code point (OP_CODE)
    err_code_t   err;
  } cmd_t;

endpackage

/* hdl/jsu_if.sv */
// ----------------------------------------------------------------------------
// jsu_if: valid/ready channels of the JSON string unescaper
// jsu_in_if carries one byte of JSON text per word, jsu_out_if one result.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_mark;

  modport source (output valid, output in_byte, output end_mark, input ready);
  modport sink   (input valid, input in_byte, input end_mark, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] err_code;
  logic       last_of_run;

  modport source (output valid, output out_kind, output out_byte, output err_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input err_code,
                  input last_of_run, output ready);
endinterface

/* hdl/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front: JSON string parser front end
// Accepts one text byte per cycle while the command queue is not full, tracks the string
// phase and the \u escape state, and pushes one command per byte that produces any result.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic           clk,
  input  logic           rst,
  jsu_in_if.sink         in_ch,
  input  logic           cmd_full,
  output logic           cmd_push,
  output jsu_pkg::cmd_t  cmd
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  // Returns {valid, value} for one hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_accum, code_accum_next;
  logic [15:0] held, held_next;

  logic        accept;
  logic [7:0]  b;
  logic [4:0]  hd;
  logic [15:0] code;
  logic        do_body, do_esc, do_code, clear;

  assign in_ch.ready = !cmd_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign b = in_ch.in_byte;
  assign hd = hex_digit(b);
  assign code = {code_accum[11:0], hd[3:0]};

  always_comb begin
    phase_next = phase;
    hex_count_next = hex_count;
    code_accum_next = code_accum;
    held_next = held;
    cmd = '{held_en: 1'b0, held: held, op: OP_NONE, val: 21'd0, err: ERR_MISSING_QUOTE};
    do_body = 1'b0;
    do_esc = 1'b0;
    do_code = 1'b0;
    clear = 1'b0;
    if (accept) begin
      if (in_ch.end_mark) begin
        cmd.held_en = (phase == PH_PAIR_BS) || (phase == PH_PAIR_U) || (phase == PH_HEX2);
        cmd.op = OP_ERROR;
        cmd.err = ERR_END_OF_INPUT;
        clear = 1'b1;
      end else begin
        unique case (phase) inside
          PH_IDLE: begin
            if (b == CH_QUOTE) begin
              phase_next = PH_BODY;
            end else if (!(b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB)) begin
              cmd.op = OP_ERROR;
              cmd.err = ERR_MISSING_QUOTE;
              clear = 1'b1;
            end
          end
          PH_BODY: do_body = 1'b1;
          PH_ESC:  do_esc = 1'b1;
          PH_HEX, PH_HEX2: begin
            if (!hd[4]) begin
              cmd.held_en = (phase == PH_HEX2);
              cmd.op = OP_ERROR;
              cmd.err = ERR_BAD_UNICODE;
              clear = 1'b1;
            end else if (hex_count != 2'd3) begin
              hex_count_next = hex_count + 2'd1;
              code_accum_next = code;
            end else begin
              hex_count_next = 2'd0;
              code_accum_next = 16'd0;
              if (phase == PH_HEX2 && code >= 16'hDC00 && code <= 16'hDFFF) begin
                // Surrogate pair joined into a supplementary code point.
                cmd.op = OP_CODE;
                cmd.val = 21'h10000 + {1'b0, 10'(held - 16'hD800), 10'd0}
                        + 21'(code - 16'hDC00);
                held_next = 16'd0;
                phase_next = PH_BODY;
              end else begin
                cmd.held_en = (phase == PH_HEX2);
                held_next = 16'd0;
                do_code = 1'b1;
              end
            end
          end
          PH_PAIR_BS: begin
            if (b == CH_BSLASH) begin
              phase_next = PH_PAIR_U;
            end else begin
              cmd.held_en = 1'b1;
              held_next = 16'd0;
              do_body = 1'b1;
            end
          end
          PH_PAIR_U: begin
            if (b == CH_U) begin
              hex_count_next = 2'd0;
              code_accum_next = 16'd0;
              phase_next = PH_HEX2;
            end else begin
              cmd.held_en = 1'b1;
              held_next = 16'd0;
              do_esc = 1'b1;
            end
          end
          default: clear = 1'b1;
        endcase
      end

      if (do_body) begin
        if (b == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else if (b == CH_QUOTE) begin
          cmd.op = OP_CLOSE;
          clear = 1'b1;
        end else begin
          cmd.op = OP_BYTE;
          cmd.val = {13'd0, b};
          phase_next = PH_BODY;
        end
      end

      if (do_esc) begin
        cmd.op = OP_BYTE;
        phase_next = PH_BODY;
        case (b) inside
          CH_QUOTE, CH_BSLASH, CH_SLASH: cmd.val = {13'd0, b};
          CH_B: cmd.val = 21'h08;
          CH_F: cmd.val = 21'h0C;
          CH_N: cmd.val = 21'h0A;
          CH_R: cmd.val = 21'h0D;
          CH_T: cmd.val = 21'h09;
          CH_U: begin
            cmd.op = OP_NONE;
            hex_count_next = 2'd0;
            code_accum_next = 16'd0;
            phase_next = PH_HEX;
          end
          default: begin
            cmd.op = OP_ERROR;
            cmd.err = ERR_BAD_ESCAPE;
            clear = 1'b1;
          end
        endcase
      end

      if (do_code) begin
        if (code >= 16'hD800 && code <= 16'hDBFF) begin
          held_next = code;
          phase_next = PH_PAIR_BS;
        end else begin
          cmd.op = OP_CODE;
          cmd.val = {5'd0, code};
          phase_next = PH_BODY;
        end
      end

      if (clear) begin
        phase_next = PH_IDLE;
        hex_count_next = 2'd0;
        code_accum_next = 16'd0;
        held_next = 16'd0;
      end
    end
  end

  assign cmd_push = accept && (cmd.held_en || cmd.op != OP_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      hex_count <= 2'd0;
      code_accum <= 16'd0;
      held <= 16'd0;
    end else begin
      phase <= phase_next;
      hex_count <= hex_count_next;
      code_accum <= code_accum_next;
      held <= held_next;
    end
  end

endmodule

/* hdl/jsu_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// jsu_cmd_fifo: command queue between parser and encoder
// A small register FIFO that lets the front end keep taking bytes while the
// back end drains multi-byte results.
// ----------------------------------------------------------------------------
module jsu_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jsu_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output jsu_pkg::cmd_t  head
);
  import jsu_pkg::*;

  cmd_t                 mem [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  assign full = (count == CMD_CNT_W'(CMD_DEPTH));
  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back: UTF-8 encoder back end
// Takes one command at a time and emits its result words, one per cycle while
// the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_avail,
  input  jsu_pkg::cmd_t  cmd_head,
  output logic           cmd_pop,
  jsu_out_if.source      out_ch
);
  import jsu_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  logic [2:0] idx;

  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] err_code;
  logic       last_of_run;

  logic [2:0] held_len, op_len, total;
  logic [2:0] k;
  logic [7:0] cp_bytes [4];
  logic [7:0] w_byte;
  logic [1:0] w_kind;
  logic [1:0] w_err;
  logic       advance, take_word, is_last;

  always_comb begin
    held_len = cur.held_en ? 3'd3 : 3'd0;
    case (cur.op)
      OP_NONE: op_len = 3'd0;
      OP_CODE: begin
        if (cur.val < 21'h80) begin
          op_len = 3'd1;
        end else if (cur.val < 21'h800) begin
          op_len = 3'd2;
        end else if (cur.val < 21'h10000) begin
          op_len = 3'd3;
        end else begin
          op_len = 3'd4;
        end
      end
      default: op_len = 3'd1;
    endcase
    total = held_len + op_len;

    // UTF-8 bytes of the code point, lead byte first.
    cp_bytes[0] = {1'b0, cur.val[6:0]};
    cp_bytes[1] = 8'h00;
    cp_bytes[2] = 8'h00;
    cp_bytes[3] = 8'h00;
    case (op_len)
      3'd2: begin
        cp_bytes[0] = {3'b110, cur.val[10:6]};
        cp_bytes[1] = {2'b10, cur.val[5:0]};
      end
      3'd3: begin
        cp_bytes[0] = {4'b1110, cur.val[15:12]};
        cp_bytes[1] = {2'b10, cur.val[11:6]};
        cp_bytes[2] = {2'b10, cur.val[5:0]};
      end
      3'd4: begin
        cp_bytes[0] = {5'b11110, cur.val[20:18]};
        cp_bytes[1] = {2'b10, cur.val[17:12]};
        cp_bytes[2] = {2'b10, cur.val[11:6]};
        cp_bytes[3] = {2'b10, cur.val[5:0]};
      end
      default: ;
    endcase

    w_kind = KIND_BYTE;
    w_byte = 8'h00;
    w_err = 2'd0;
    k = idx - held_len;
    if (idx < held_len) begin
      case (idx)
        3'd0:    w_byte = {4'b1110, cur.held[15:12]};
        3'd1:    w_byte = {2'b10, cur.held[11:6]};
        default: w_byte = {2'b10, cur.held[5:0]};
      endcase
    end else begin
      case (cur.op)
        OP_BYTE: w_byte = cur.val[7:0];
        OP_CODE: w_byte = cp_bytes[k[1:0]];
        OP_CLOSE: w_kind = KIND_CLOSE;
        OP_ERROR: begin
          w_kind = KIND_ERROR;
          w_err = cur.err;
        end
        default: ;
      endcase
    end
  end

  assign advance = !out_valid || out_ch.ready;
  assign take_word = cur_valid && advance;
  assign is_last = (idx == total - 3'd1);
  assign cmd_pop = cmd_avail && (!cur_valid || (take_word && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        cur_valid <= 1'b1;
        idx <= 3'd0;
      end else if (take_word && is_last) begin
        cur_valid <= 1'b0;
      end else if (take_word) begin
        idx <= idx + 3'd1;
      end
      if (advance) begin
        out_valid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd_head;
    end
    if (take_word) begin
      out_kind <= w_kind;
      out_byte <= w_byte;
      err_code <= w_err;
      last_of_run <= is_last;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.out_kind = out_kind;
  assign out_ch.out_byte = out_byte;
  assign out_ch.err_code = err_code;
  assign out_ch.last_of_run = last_of_run;

endmodule

/* hdl/json_string_unescape_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string body to UTF-8 converter
// Skips whitespace up to an opening quote, then decodes escapes and \uXXXX
// sequences (including surrogate pairs) of the string body into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
// in_ch takes one word per cycle while ready is high: a byte of JSON text, or
// end_mark to say the input has ended. out_ch gives result words: a decoded
// byte, a string-closed mark, or an error code; last_of_run flags the final
// word caused by one input word. A byte may give no word (whitespace, quotes
// that open a string, hex digits) or up to six words (a lone surrogate
// released plus a new code). Plain characters flow at one word per cycle while
// the receiver is ready; a command with several result words holds the encoder
// until its last word is taken, while the front end keeps accepting bytes
// until the four-entry command queue is full. When the receiver stalls, the
// output register holds its word, the queue fills and in_ch.ready falls.
// Synchronous reset empties the queue and the output stage and returns the
// parser to waiting for an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);
  import jsu_pkg::*;

  // Commands from the parser: one per input word that yields any result.
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic not_empty;

  // Front end: phase tracking, escape and hex decoding, surrogate holding.
  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cmd_full (full),
    .cmd_push (push),
    .cmd      (push_cmd)
  );

  // The queue decouples byte intake from the multi-word UTF-8 expansion.
  jsu_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head_cmd)
  );

  // Back end: walks each command's words into the output register.
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (not_empty),
    .cmd_head  (head_cmd),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

/* sim/json_string_unescape_utf8_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_checker: result predictor and scoreboard
// Watches both channels of the unescaper. Every accepted input word runs
// through a behavioral copy of the string decoder, and the words it should
// cause are queued. Every accepted output word is compared with the oldest
// queued word.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_checker (
  input  logic clk,
  input  logic rst,
  jsu_in_if    in_ch,
  jsu_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import jsu_pkg::*;

  localparam int         REPORT_LIMIT = 10;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BSLASH    = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  // Outside of error words the error field reads zero.
  localparam err_code_t  NO_ERR       = ERR_MISSING_QUOTE;

  typedef struct packed {
    out_kind_t  kind;
    logic [7:0] data;
    err_code_t  err;
    logic       last;
  } utf8_word_t;

  utf8_word_t  utf8_expected[$];
  utf8_word_t  run_words[$];

  phase_t      parse_phase;
  logic [1:0]  digit_cnt;
  logic [15:0] code_unit;
  logic [15:0] held_hi;

  function automatic void emit(out_kind_t kind, logic [7:0] data, err_code_t err);
    utf8_word_t w;
    w.kind = kind;
    w.data = data;
    w.err  = err;
    w.last = 1'b0;
    run_words.insert(run_words.size(), w);
  endfunction

  function automatic void encode_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(KIND_BYTE, cp[7:0], NO_ERR);
    end else if (cp < 21'h800) begin
      emit(KIND_BYTE, {3'b110, cp[10:6]}, NO_ERR);
      emit(KIND_BYTE, {2'b10, cp[5:0]}, NO_ERR);
    end else if (cp < 21'h10000) begin
      emit(KIND_BYTE, {4'b1110, cp[15:12]}, NO_ERR);
      emit(KIND_BYTE, {2'b10, cp[11:6]}, NO_ERR);
      emit(KIND_BYTE, {2'b10, cp[5:0]}, NO_ERR);
    end else begin
      emit(KIND_BYTE, {5'b11110, cp[20:18]}, NO_ERR);
      emit(KIND_BYTE, {2'b10, cp[17:12]}, NO_ERR);
      emit(KIND_BYTE, {2'b10, cp[11:6]}, NO_ERR);
      emit(KIND_BYTE, {2'b10, cp[5:0]}, NO_ERR);
    end
  endfunction

  function automatic void clear_parse();
    parse_phase = PH_IDLE;
    digit_cnt   = 2'd0;
    code_unit   = 16'h0000;
    held_hi     = 16'h0000;
  endfunction

  function automatic void raise_error(err_code_t err);
    emit(KIND_ERROR, 8'h00, err);
    clear_parse();
  endfunction

  function automatic void release_held();
    encode_utf8({5'd0, held_hi});
    held_hi = 16'h0000;
  endfunction

  function automatic void take_unit(logic [15:0] u);
    if (u >= 16'hD800 && u <= 16'hDBFF) begin
      held_hi     = u;
      parse_phase = PH_PAIR_BS;
    end else begin
      encode_utf8({5'd0, u});
      parse_phase = PH_BODY;
    end
  endfunction

  function automatic void body_char(logic [7:0] c);
    if (c == CH_BSLASH) begin
      parse_phase = PH_ESC;
    end else if (c == CH_QUOTE) begin
      emit(KIND_CLOSE, 8'h00, NO_ERR);
      clear_parse();
    end else begin
      emit(KIND_BYTE, c, NO_ERR);
      parse_phase = PH_BODY;
    end
  endfunction

  function automatic void escape_char(logic [7:0] c);
    logic [7:0] v;
    case (c) inside
      CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
      "b": v = 8'h08;
      "f": v = 8'h0C;
      "n": v = 8'h0A;
      "r": v = 8'h0D;
      "t": v = 8'h09;
      "u": begin
        digit_cnt   = 2'd0;
        code_unit   = 16'h0000;
        parse_phase = PH_HEX;
        return;
      end
      default: begin
        raise_error(ERR_BAD_ESCAPE);
        return;
      end
    endcase
    emit(KIND_BYTE, v, NO_ERR);
    parse_phase = PH_BODY;
  endfunction

  function automatic int digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void take_digit(logic [7:0] c, bit second);
    int          d;
    logic [15:0] u;
    logic [20:0] cp;
    d = digit_value(c);
    if (d < 0) begin
      if (second) release_held();
      raise_error(ERR_BAD_UNICODE);
      return;
    end
    code_unit = {code_unit[11:0], 4'(d)};
    if (digit_cnt != 2'd3) begin
      digit_cnt++;
      return;
    end
    u         = code_unit;
    digit_cnt = 2'd0;
    code_unit = 16'h0000;
    if (second && u >= 16'hDC00 && u <= 16'hDFFF) begin
      cp = 21'h10000 + ({11'd0, held_hi[9:0]} << 10) + {11'd0, u[9:0]};
      held_hi = 16'h0000;
      encode_utf8(cp);
      parse_phase = PH_BODY;
      return;
    end
    if (second) release_held();
    take_unit(u);
  endfunction

  function automatic void predict_word(logic [7:0] c, logic end_flag);
    run_words.delete();
    if (end_flag) begin
      if (parse_phase inside {PH_PAIR_BS, PH_PAIR_U, PH_HEX2}) release_held();
      raise_error(ERR_END_OF_INPUT);
    end else begin
      case (parse_phase)
        PH_BODY: body_char(c);
        PH_ESC:  escape_char(c);
        PH_HEX:  take_digit(c, 1'b0);
        PH_PAIR_BS: begin
          if (c == CH_BSLASH) begin
            parse_phase = PH_PAIR_U;
          end else begin
            release_held();
            body_char(c);
          end
        end
        PH_PAIR_U: begin
          if (c == "u") begin
            digit_cnt   = 2'd0;
            code_unit   = 16'h0000;
            parse_phase = PH_HEX2;
          end else begin
            release_held();
            escape_char(c);
          end
        end
        PH_HEX2: take_digit(c, 1'b1);
        default: begin
          if (c == CH_QUOTE) begin
            clear_parse();
            parse_phase = PH_BODY;
          end else if (!(c inside {8'h20, 8'h0A, 8'h0D, 8'h09})) begin
            raise_error(ERR_MISSING_QUOTE);
          end
        end
      endcase
    end
    if (run_words.size() != 0) run_words[run_words.size() - 1].last = 1'b1;
    foreach (run_words[i]) utf8_expected.insert(utf8_expected.size(), run_words[i]);
  endfunction

  function automatic void check_word();
    utf8_word_t seen;
    utf8_word_t want;
    seen.kind = out_kind_t'(out_ch.out_kind);
    seen.data = out_ch.out_byte;
    seen.err  = err_code_t'(out_ch.err_code);
    seen.last = out_ch.last_of_run;
    if (utf8_expected.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: unexpected output word: kind %0d byte %02h err %0d last %0b",
                 $time, seen.kind, seen.data, seen.err, seen.last);
    end else begin
      want = utf8_expected.pop_front();
      if (seen !== want) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: expected k%0d b%02h e%0d l%0b, got k%0d b%02h e%0d l%0b",
                   $time, want.kind, want.data, want.err, want.last,
                   seen.kind, seen.data, seen.err, seen.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      utf8_expected.delete();
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_word(in_ch.in_byte, in_ch.end_mark);
      if (out_ch.valid && out_ch.ready) check_word();
    end
    pending = utf8_expected.size();
  end

endmodule

/* sim/json_string_unescape_utf8_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb: testbench of the JSON string unescaper
// Feeds JSON text, one byte per word, through directed cases and then random
// strings full of escapes, \u sequences and surrogate pairs, with noise and
// broken sequences mixed in. Sender gaps and receiver stalls vary by phase.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;

  // The run is tiny next to this; only a hang can reach it.
  localparam int         CYCLE_LIMIT = 500000;
  // Long receiver hold-off: far longer than the four-entry command queue and
  // the output register can absorb, so in_ch.ready must fall.
  localparam int         HOLD_CYCLES = 300;
  // This leaves ample margin for words still in flight once nothing more is
  // expected.
  localparam int         TAIL_CYCLES = 20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_U        = 8'h75;

  logic       clk = 1'b0;
  logic       rst;
  int         fail_count;
  int         pending;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_requests = 0;
  int         cycle_count = 0;
  int         queued_items = 0;
  // Text waiting to be sent: bit 8 is end_mark, bits 7:0 the byte.
  logic [8:0] text_q[$];

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape_utf8 i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  json_string_unescape_utf8_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver. Each new hold request from the stimulus holds ready low for a
  // long stretch; otherwise ready follows the stall rate of the phase.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] hex_ascii(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    case ($urandom_range(0, 7))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return "/";
      3:       return "b";
      4:       return "f";
      5:       return "n";
      6:       return "r";
      default: return "t";
    endcase
  endfunction

  // Code units spread over every UTF-8 length and both surrogate halves,
  // with the range boundaries picked out now and then.
  function automatic logic [15:0] pick_unit();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: return 16'($urandom_range(16'h800, 16'hFFFF));
      3: return 16'($urandom_range(16'hD800, 16'hDBFF));
      4: return 16'($urandom_range(16'hDC00, 16'hDFFF));
      default: begin
        case ($urandom_range(0, 7))
          0:       return 16'h0000;
          1:       return 16'h007F;
          2:       return 16'h0080;
          3:       return 16'h07FF;
          4:       return 16'h0800;
          5:       return 16'hFFFF;
          6:       return 16'hDBFF;
          default: return 16'hDC00;
        endcase
      end
    endcase
  endfunction

  task automatic add_word(input logic end_flag, input logic [7:0] c);
    text_q.insert(text_q.size(), {end_flag, c});
    queued_items++;
  endtask

  task automatic add_chars(input string s);
    for (int i = 0; i < s.len(); i++) add_word(1'b0, s[i]);
  endtask

  // A \uXXXX escape, hex digits in random case.
  task automatic add_hex_escape(input logic [15:0] u);
    add_word(1'b0, CH_BSLASH);
    add_word(1'b0, CH_U);
    for (int i = 3; i >= 0; i--) begin
      add_word(1'b0, hex_ascii(u[i*4 +: 4], 1'($urandom_range(0, 1))));
    end
  endtask

  // One piece of JSON text: optional blanks, then mostly a well-formed string
  // with random content. Some elements break the string on purpose (bad
  // escape, bad hex digit, end of input); the string then stops there, since
  // the block is back to waiting for a quote.
  task automatic add_fragment();
    logic [7:0]  c;
    logic [15:0] u;
    bit          broken;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       add_word(1'b0, 8'h20);
        1:       add_word(1'b0, 8'h0A);
        2:       add_word(1'b0, 8'h0D);
        default: add_word(1'b0, 8'h09);
      endcase
    end
    // Noise outside any string: a stray byte or an early end of input.
    if ($urandom_range(0, 15) == 0) begin
      add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      return;
    end
    add_word(1'b0, CH_QUOTE);
    broken = 1'b0;
    repeat ($urandom_range(0, 6)) begin
      if (!broken) begin
        case ($urandom_range(0, 15)) inside
          [0:5]: begin
            // Plain content over the full byte range.
            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            add_word(1'b0, c);
          end
          [6:7]: begin
            add_word(1'b0, CH_BSLASH);
            add_word(1'b0, pick_escape_letter());
          end
          [8:9]: add_hex_escape(pick_unit());
          10: begin
            // Proper surrogate pair, joined into one supplementary code point.
            add_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
            add_hex_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
          end
          11: begin
            // High surrogate with a partner that does not fit: the held half
            // must come out on its own before the follow-up is handled.
            add_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
            case ($urandom_range(0, 2))
              0: begin
                add_word(1'b0, CH_BSLASH);
                add_word(1'b0, pick_escape_letter());
              end
              1: begin
                do u = pick_unit(); while (u >= 16'hDC00 && u <= 16'hDFFF);
                add_hex_escape(u);
              end
              default: begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
                add_word(1'b0, c);
                broken = (c == CH_QUOTE);
              end
            endcase
          end
          12: begin
            // Bad hex digit, sometimes in the second half of a pair.
            if ($urandom_range(0, 1)) begin
              add_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
            end
            add_word(1'b0, CH_BSLASH);
            add_word(1'b0, CH_U);
            repeat ($urandom_range(0, 3))
              add_word(1'b0, hex_ascii(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            case ($urandom_range(0, 7))
              0:       c = 8'h2F;  // just below '0'
              1:       c = 8'h3A;  // just above '9'
              2:       c = 8'h40;  // just below 'A'
              3:       c = "G";
              4:       c = 8'h60;  // just below 'a'
              5:       c = "g";
              6:       c = CH_QUOTE;
              default: c = 8'hFF;
            endcase
            add_word(1'b0, c);
            broken = 1'b1;
          end
          13: begin
            add_word(1'b0, CH_BSLASH);
            do c = 8'($urandom_range(0, 255));
            while (c inside {CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", "u"});
            add_word(1'b0, c);
            broken = 1'b1;
          end
          14: begin
            // End of input inside the string, now and then with a held half.
            if ($urandom_range(0, 1)) begin
              add_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
            end
            add_word(1'b1, 8'($urandom_range(0, 255)));
            broken = 1'b1;
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       add_word(1'b0, 8'h00);
              1:       add_word(1'b0, 8'h7F);
              2:       add_word(1'b0, 8'h80);
              default: add_word(1'b0, 8'hFF);
            endcase
          end
        endcase
      end
    end
    if (!broken) add_word(1'b0, CH_QUOTE);
  endtask

  // Offers one word and returns once it has been taken. Valid stays high
  // between back-to-back words; a gap lowers it only in steps of its own.
  task automatic send_word(input logic [8:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.end_mark <= w[8];
    in_ch.in_byte  <= w[7:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_text();
    while (text_q.size() != 0) send_word(text_q.pop_front());
  endtask

  // Sender pauses until every predicted word has come out. The checker
  // updates its count at the rising edge, so it is read at the falling one.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int goal;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal = queued_items + n_items;
    while (queued_items < goal) begin
      add_fragment();
      send_text();
    end
    drain_results();
  endtask

  initial begin : stimulus
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    in_ch.end_mark = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed text, no gaps: stray byte before any quote, blank then the
    // opening quote, extreme plain bytes, a surrogate pair, a high surrogate
    // left alone by plain content, a closing quote, a bad escape letter, and
    // an end of input while waiting for a string.
    add_chars("x");
    add_chars("\t\"");
    add_word(1'b0, 8'hFF);
    add_word(1'b0, 8'h00);
    add_chars("\\uD800\\udc00");
    add_chars("\\uDBFF");
    add_chars("A\"");
    add_chars("\"\\g");
    add_word(1'b1, 8'hA5);
    send_text();
    drain_results();

    // Random text under each idling pattern.
    run_phase(0, 0, 30);
    run_phase(75, 0, 30);

    // Receiver holds off for a long stretch while the sender keeps going, so
    // the command queue fills and the input side must stall.
    hold_requests <= hold_requests + 1;
    run_phase(0, 0, 30);

    run_phase(0, 75, 30);
    run_phase(14, 14, 30);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/jsu_pkg.sv
hdl/jsu_if.sv
hdl/jsu_front.sv
hdl/jsu_cmd_fifo.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8.sv
sim/json_string_unescape_utf8_checker.sv
sim/json_string_unescape_utf8_tb.sv
